@@ hw/rtl/grid_path_segment_interpolator_top_defines.svh @@
// assertion macros for the grid path segment interpolator
// used by the top level; expects clk and rst_n in scope
`ifndef GRID_PATH_SEGMENT_INTERPOLATOR_TOP_DEFINES_SVH
`define GRID_PATH_SEGMENT_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GPSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpsi assertion failed");
`define GPSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpsi assertion failed");
`else
`define GPSI_ASSERT_IMP(lbl, ante, cons)
`define GPSI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/gpsi_pkg.sv @@
// shared types for the grid path segment interpolator
// command and status structs between controller and datapath
package gpsi_pkg;

  localparam logic OP_CELL_WR = 1'b0;
  localparam logic OP_WAYPT   = 1'b1;
  localparam logic [7:0] RES_RESET = 8'd16;

  typedef struct packed {
    logic clr_en;
    logic cell_wr;
    logic path_open;
    logic load_in;
    logic div_step;
    logic seg_init;
    logic pt_calc;
    logic pt_adv;
    logic cand_take;
    logic push_pend;
    logic push_last;
    logic seg_end;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_wpt;
    logic start_path;
    logic div_done;
    logic cand_ok;
    logic k_last;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/gpsi_ifs.sv @@
// channel interfaces: input items, result items, configuration writes
// field widths are fixed by the item format
interface gpsi_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] coord_x;
  logic [3:0] coord_y;
  logic [3:0] coord_z;
  logic       present;
  logic       path_start;
  modport source (output valid, opcode, coord_x, coord_y, coord_z, present, path_start,
                  input ready);
  modport sink (input valid, opcode, coord_x, coord_y, coord_z, present, path_start,
                output ready);
endinterface

interface gpsi_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_x;
  logic [3:0] out_y;
  logic [3:0] out_z;
  logic       last;
  modport source (output valid, out_x, out_y, out_z, last, input ready);
  modport sink (input valid, out_x, out_y, out_z, last, output ready);
endinterface

interface gpsi_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/gpsi_dp.sv @@
// datapath: cell map, step divider, segment walker, pending and output registers
// depends on gpsi_pkg for command and status structs
module gpsi_dp #(
  parameter int GRID_SIDE = 16,
  parameter int MAX_STEPS = 63
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gpsi_pkg::cmd_t     cmd,
  output gpsi_pkg::status_t  st,
  input  logic               in_opcode,
  input  logic [3:0]         in_x,
  input  logic [3:0]         in_y,
  input  logic [3:0]         in_z,
  input  logic               in_present,
  input  logic               in_path_start,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_x,
  output logic [3:0]         out_y,
  output logic [3:0]         out_z,
  output logic               out_last
);

  localparam logic [5:0] MaxSteps = 6'(MAX_STEPS);
  localparam logic [4:0] GridSide = 5'(GRID_SIDE);

  // half-up rounding of num/steps, quotient known to fit in four bits
  function automatic logic [3:0] lerp_q(input logic [9:0] num, input logic [5:0] stp);
    logic [10:0] n;
    logic [10:0] t;
    logic [3:0]  q;
    n = {num, 1'b0} + 11'(stp);
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      t = 11'({stp, 1'b0}) << i;
      if (n >= t) begin
        n = n - t;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic in_grid(input logic [3:0] a, input logic [3:0] b,
                                   input logic [3:0] c);
    return ({1'b0, a} < GridSide) && ({1'b0, b} < GridSide) && ({1'b0, c} < GridSide);
  endfunction

  logic        mem_r [4096];
  logic        mem_q_r;
  logic [11:0] clr_cnt_r;
  logic [7:0]  res_r;
  logic [11:0] prev_r;
  logic        have_prev_r;
  logic [11:0] last_r;
  logic        have_last_r;
  logic [3:0]  cur_r [3];
  logic [3:0]  mag_r [3];
  logic        neg_r [3];
  logic [9:0]  num_r [3];
  logic [5:0]  steps_r;
  logic [5:0]  k_r;
  logic [8:0]  div_num_r;
  logic [8:0]  div_quo_r;
  logic [7:0]  div_rem_r;
  logic [3:0]  div_cnt_r;
  logic [3:0]  pt_r [3];
  logic        pt_in_r;
  logic [11:0] pend_r;
  logic        pend_valid_r;
  logic        out_valid_r;
  logic [11:0] out_cell_r;
  logic        out_last_r;

  logic [3:0]  in_c [3];
  logic [3:0]  from_c [3];
  logic [3:0]  mag_c [3];
  logic [3:0]  m_c;
  logic [8:0]  div_init_c;
  logic [8:0]  div_trial_c;
  logic [5:0]  steps_c;
  logic [11:0] cand_c;
  logic        mem_we;
  logic [11:0] mem_wa;
  logic        mem_wd;
  logic        out_free_c;

  assign in_c[0] = in_x;
  assign in_c[1] = in_y;
  assign in_c[2] = in_z;
  assign from_c[0] = prev_r[3:0];
  assign from_c[1] = prev_r[7:4];
  assign from_c[2] = prev_r[11:8];

  always_comb begin
    m_c = 4'd1;
    for (int a = 0; a < 3; a++) begin
      mag_c[a] = (in_c[a] >= from_c[a]) ? in_c[a] - from_c[a] : from_c[a] - in_c[a];
      if (mag_c[a] > m_c) m_c = mag_c[a];
    end
  end

  // ceil(m*16/res) as floor((m*16 + res - 1)/res)
  assign div_init_c  = 9'({m_c, 4'b0000}) + 9'(res_r) - 9'd1;
  assign div_trial_c = {div_rem_r, div_num_r[8]};

  always_comb begin
    if (res_r == 8'd0) begin
      steps_c = MaxSteps;
    end else if (div_quo_r > 9'(MaxSteps)) begin
      steps_c = MaxSteps;
    end else if (div_quo_r == 9'd0) begin
      steps_c = 6'd1;
    end else begin
      steps_c = div_quo_r[5:0];
    end
  end

  assign cand_c = {pt_r[2], pt_r[1], pt_r[0]};
  assign out_free_c = !out_valid_r || out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_cnt_r;
    mem_wd = 1'b0;
    if (cmd.clr_en) begin
      mem_we = 1'b1;
    end else if (cmd.cell_wr && in_grid(in_x, in_y, in_z)) begin
      mem_we = 1'b1;
      mem_wa = {in_z, in_y, in_x};
      mem_wd = in_present;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (cmd.pt_calc) mem_q_r <= mem_r[{lerp_q(num_r[2], steps_r),
                                       lerp_q(num_r[1], steps_r),
                                       lerp_q(num_r[0], steps_r)}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      res_r        <= gpsi_pkg::RES_RESET;
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      last_r       <= '0;
      have_last_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
    end else begin
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + 12'd1;
      if (cfg_valid) res_r <= cfg_data;
      if (cmd.path_open) begin
        prev_r      <= {in_z, in_y, in_x};
        have_prev_r <= 1'b1;
        have_last_r <= 1'b0;
      end
      if (cmd.load_in) div_cnt_r <= 4'd9;
      else if (cmd.div_step) div_cnt_r <= div_cnt_r - 4'd1;
      if (cmd.seg_end) prev_r <= {cur_r[2], cur_r[1], cur_r[0]};
      if (cmd.cand_take) begin
        last_r       <= cand_c;
        have_last_r  <= 1'b1;
      end
      if (cmd.cand_take) pend_valid_r <= 1'b1;
      else if (cmd.push_pend) pend_valid_r <= 1'b0;
      if (cmd.push_pend) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int a = 0; a < 3; a++) begin
        cur_r[a] <= in_c[a];
        mag_r[a] <= mag_c[a];
        neg_r[a] <= in_c[a] < from_c[a];
      end
      div_num_r <= div_init_c;
      div_quo_r <= '0;
      div_rem_r <= '0;
    end
    if (cmd.div_step) begin
      div_num_r <= {div_num_r[7:0], 1'b0};
      if (div_trial_c >= 9'(res_r) && res_r != 8'd0) begin
        div_rem_r <= 8'(div_trial_c - 9'(res_r));
        div_quo_r <= {div_quo_r[7:0], 1'b1};
      end else begin
        div_rem_r <= div_trial_c[7:0];
        div_quo_r <= {div_quo_r[7:0], 1'b0};
      end
    end
    if (cmd.seg_init) begin
      steps_r <= steps_c;
      k_r     <= '0;
      for (int a = 0; a < 3; a++) num_r[a] <= 10'(from_c[a] * steps_c);
    end
    if (cmd.pt_calc) begin
      for (int a = 0; a < 3; a++) pt_r[a] <= lerp_q(num_r[a], steps_r);
      pt_in_r <= in_grid(lerp_q(num_r[0], steps_r), lerp_q(num_r[1], steps_r),
                         lerp_q(num_r[2], steps_r));
    end
    if (cmd.pt_adv) begin
      k_r <= k_r + 6'd1;
      for (int a = 0; a < 3; a++) begin
        num_r[a] <= neg_r[a] ? num_r[a] - 10'(mag_r[a]) : num_r[a] + 10'(mag_r[a]);
      end
    end
    if (cmd.cand_take) pend_r <= cand_c;
    if (cmd.push_pend) begin
      out_cell_r <= pend_r;
      out_last_r <= cmd.push_last;
    end
  end

  assign st.clr_done   = clr_cnt_r == 12'hFFF;
  assign st.is_wpt     = in_opcode == gpsi_pkg::OP_WAYPT;
  assign st.start_path = in_path_start || !have_prev_r;
  assign st.div_done   = div_cnt_r == 4'd0;
  assign st.cand_ok    = pt_in_r && mem_q_r && !(have_last_r && last_r == cand_c);
  assign st.k_last     = k_r == steps_r;
  assign st.pend_valid = pend_valid_r;
  assign st.out_free   = out_free_c;

  assign out_valid = out_valid_r;
  assign out_x     = out_cell_r[3:0];
  assign out_y     = out_cell_r[7:4];
  assign out_z     = out_cell_r[11:8];
  assign out_last  = out_last_r;

endmodule

@@ hw/rtl/gpsi_ctrl.sv @@
// controller: clearing pass, item dispatch, divider and segment walk sequencing
// depends on gpsi_pkg for command and status structs
module gpsi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpsi_pkg::status_t  st,
  output gpsi_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_CALC, S_CHK, S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (!st.is_wpt) begin
            cmd.cell_wr = 1'b1;
          end else if (st.start_path) begin
            cmd.path_open = 1'b1;
          end else begin
            cmd.load_in = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          cmd.seg_init = 1'b1;
          state_nxt = S_CALC;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CALC: begin
        cmd.pt_calc = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // a new candidate pushes the held one out, so it needs a free slot
        if (!(st.cand_ok && st.pend_valid && !st.out_free)) begin
          if (st.cand_ok) begin
            cmd.cand_take = 1'b1;
            cmd.push_pend = st.pend_valid;
          end
          if (st.k_last) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.pt_adv = 1'b1;
            state_nxt = S_CALC;
          end
        end
      end
      S_FLUSH: begin
        if (!st.pend_valid) begin
          cmd.seg_end = 1'b1;
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.push_pend = 1'b1;
          cmd.push_last = 1'b1;
          cmd.seg_end = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/grid_path_segment_interpolator_top.sv @@
// top level of the grid path segment interpolator
// depends on gpsi_pkg, gpsi_ifs, gpsi_ctrl, gpsi_dp and the defines header
`include "grid_path_segment_interpolator_top_defines.svh"

// After reset the cell map is cleared and no item is taken (configuration writes are).
// A cell write or a path-start waypoint is handled in the idle state. Any other waypoint
// runs the divider, then walks steps+1 points and flushes, with steps up to 63: the step
// count comes from a one-bit-per-cycle divider, then each interpolated point is rounded
// and its cell map entry read in one state, checked in the next. Results leave through
// an output register; a stalled sink holds the walk. The final cell of a waypoint
// carries last, so each emitted cell is held until the next is known.
module grid_path_segment_interpolator_top #(
  parameter int GRID_SIDE = 16,
  parameter int MAX_STEPS = 63
) (
  input logic          clk,
  input logic          rst_n,
  gpsi_in_if.sink      in_ch,
  gpsi_out_if.source   out_ch,
  gpsi_cfg_if.sink     cfg_ch
);

  gpsi_pkg::cmd_t    cmd;
  gpsi_pkg::status_t st;

  assign cfg_ch.ready = 1'b1;

  gpsi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  gpsi_dp #(
    .GRID_SIDE (GRID_SIDE),
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_opcode     (in_ch.opcode),
    .in_x          (in_ch.coord_x),
    .in_y          (in_ch.coord_y),
    .in_z          (in_ch.coord_z),
    .in_present    (in_ch.present),
    .in_path_start (in_ch.path_start),
    .cfg_valid     (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_x         (out_ch.out_x),
    .out_y         (out_ch.out_y),
    .out_z         (out_ch.out_z),
    .out_last      (out_ch.last)
  );

  `GPSI_ASSERT_IMP(a_idle_no_pend, in_ch.ready, !st.pend_valid)
  `GPSI_ASSERT_IMP(a_push_slot_free, cmd.push_pend, st.out_free)
  `GPSI_ASSERT_IMP(a_take_not_flush, cmd.cand_take, !cmd.push_last)
  `GPSI_ASSERT_NXT(a_last_push_idle, cmd.push_last, in_ch.ready)

endmodule
